### rtl/abdd_pkg.sv
// Shared constants, register codes and the fractional power-of-two table for the
// anchor box delta decoder. No dependencies.
package abdd_pkg;

  localparam int COORD_FRAC_BITS_DEF = 4;
  localparam int DELTA_FRAC_BITS_DEF = 12;

  // register stages from input to result register
  localparam int PIPE_DEPTH = 7;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic [27:0] EXP_MAX   = 28'hFFFFFFF;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // 2^(j/16) in Q.16
  function automatic logic [16:0] pow2_frac(input logic [3:0] j);
    logic [16:0] v;
    case (j)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd68438;
      4'd2:    v = 17'd71468;
      4'd3:    v = 17'd74632;
      4'd4:    v = 17'd77936;
      4'd5:    v = 17'd81386;
      4'd6:    v = 17'd84990;
      4'd7:    v = 17'd88752;
      4'd8:    v = 17'd92682;
      4'd9:    v = 17'd96785;
      4'd10:   v = 17'd101070;
      4'd11:   v = 17'd105545;
      4'd12:   v = 17'd110218;
      4'd13:   v = 17'd115098;
      4'd14:   v = 17'd120194;
      4'd15:   v = 17'd125515;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

### rtl/abdd_axis.sv
// One axis of the box decoder: size, center shift, exp of the size delta,
// corner rounding and clipping, as a seven stage pipeline. Uses abdd_pkg.
module abdd_axis #(
  parameter int COORD_FRAC_BITS = abdd_pkg::COORD_FRAC_BITS_DEF,
  parameter int DELTA_FRAC_BITS = abdd_pkg::DELTA_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic signed [16:0] lo,
  input  logic signed [16:0] hi,
  input  logic signed [15:0] shift,
  input  logic signed [15:0] log_scale,
  input  logic [12:0]        limit,
  output logic [16:0]        box_lo,
  output logic [16:0]        box_hi
);

  localparam int D16_W   = 32 - DELTA_FRAC_BITS;
  localparam int P1_W    = D16_W + 18;
  localparam int T_W     = P1_W - 15;
  localparam int N_W     = T_W - 16;
  localparam int CTR_W   = 53 - DELTA_FRAC_BITS;
  localparam int CTR_SH  = 17 - DELTA_FRAC_BITS;
  localparam int SUM_W   = 50;
  localparam int Q_W     = SUM_W - 17;
  localparam int BOUND_W = 13 + COORD_FRAC_BITS;

  localparam logic signed [18:0] ONE      = 19'sd1 <<< COORD_FRAC_BITS;
  localparam logic signed [47:0] HALF_OFS = 48'sd1 <<< (COORD_FRAC_BITS + 16);

  // stage 1: size, corner sum, log2(e) product
  logic signed [D16_W-1:0] d16;
  logic signed [18:0]      size1;
  logic signed [17:0]      lsum1;
  logic signed [15:0]      shift1;
  logic signed [P1_W-1:0]  p1;

  assign d16 = D16_W'(log_scale) <<< (16 - DELTA_FRAC_BITS);

  always_ff @(posedge clk) begin
    size1  <= 19'(hi) - 19'(lo) + ONE;
    lsum1  <= 18'(lo) + 18'(hi);
    shift1 <= shift;
    p1     <= P1_W'(d16) * P1_W'($signed({1'b0, abdd_pkg::LOG2E_Q16}));
  end

  // stage 2: split exponent, ln2 product of the low fraction, shift * size
  logic signed [P1_W:0]    tr;
  logic signed [T_W-1:0]   t;
  logic signed [N_W-1:0]   n2;
  logic [3:0]              j2;
  logic [27:0]             ap2;
  logic signed [34:0]      ctrp2;
  logic signed [18:0]      size2;
  logic signed [17:0]      lsum2;

  assign tr = (P1_W+1)'(p1) + (P1_W+1)'(32'sd32768);
  assign t  = tr[P1_W:16];

  always_ff @(posedge clk) begin
    n2    <= t[T_W-1:16];
    j2    <= t[15:12];
    ap2   <= 28'(t[11:0]) * 28'(abdd_pkg::LN2_Q16);
    ctrp2 <= 35'(shift1) * 35'(size1);
    size2 <= size1;
    lsum2 <= lsum1;
  end

  // stage 3: polynomial term a, a*a, center
  logic [27:0]             ar;
  logic [11:0]             a;
  logic [11:0]             a3;
  logic [23:0]             aa3;
  logic signed [CTR_W-1:0] ctr3;
  logic signed [N_W-1:0]   n3;
  logic [3:0]              j3;
  logic signed [18:0]      size3;

  assign ar = ap2 + 28'd32768;
  assign a  = ar[27:16];

  always_ff @(posedge clk) begin
    a3    <= a;
    aa3   <= 24'(a) * 24'(a);
    ctr3  <= (CTR_W'(ctrp2) <<< CTR_SH) + (CTR_W'(lsum2) <<< 16);
    n3    <= n2;
    j3    <= j2;
    size3 <= size2;
  end

  // stage 4: 2^r polynomial times table entry
  logic [23:0]             aar;
  logic [16:0]             p;
  logic [33:0]             mprod4;
  logic signed [N_W-1:0]   n4;
  logic signed [18:0]      size4;
  logic signed [CTR_W-1:0] ctr4;

  assign aar = aa3 + 24'd65536;
  assign p   = 17'd65536 + 17'(a3) + 17'(aar[23:17]);

  always_ff @(posedge clk) begin
    mprod4 <= 34'(abdd_pkg::pow2_frac(j3)) * 34'(p);
    n4     <= n3;
    size4  <= size3;
    ctr4   <= ctr3;
  end

  // stage 5: scale by 2^n with rounding and saturation
  logic [34:0]             mr;
  logic [17:0]             m;
  logic signed [11:0]      n12;
  logic [11:0]             s12;
  logic [38:0]             w;
  logic [27:0]             e;
  logic [27:0]             e5;
  logic signed [18:0]      size5;
  logic signed [CTR_W-1:0] ctr5;

  assign mr  = 35'(mprod4) + 35'd32768;
  assign m   = mr[33:16];
  assign n12 = 12'(n4);
  assign s12 = 12'(-n12);

  always_comb begin
    w = '0;
    e = '0;
    if (!n12[11]) begin
      if (n12 > 12'sd20) begin
        e = abdd_pkg::EXP_MAX;
      end else begin
        w = 39'(m) << n12[4:0];
        e = (w > 39'(abdd_pkg::EXP_MAX)) ? abdd_pkg::EXP_MAX : w[27:0];
      end
    end else if (s12 < 12'd19) begin
      // m < 2^18, so right shifts of 19 or more round to zero
      w = (39'(m) + (39'd1 << (s12[4:0] - 5'd1))) >> s12[4:0];
      e = w[27:0];
    end
  end

  always_ff @(posedge clk) begin
    e5    <= e;
    size5 <= size4;
    ctr5  <= ctr4;
  end

  // stage 6: half extent
  logic signed [47:0]      half6;
  logic signed [CTR_W-1:0] ctr6;

  always_ff @(posedge clk) begin
    half6 <= 48'($signed({1'b0, e5})) * 48'(size5) - HALF_OFS;
    ctr6  <= ctr5;
  end

  // stage 7: round half up to coordinate units, clip to [0, bound]
  logic signed [SUM_W-1:0] sa;
  logic signed [SUM_W-1:0] sb;
  logic signed [Q_W-1:0]   qa;
  logic signed [Q_W-1:0]   qb;
  logic signed [Q_W-1:0]   bound;

  assign sa    = SUM_W'(ctr6) - SUM_W'(half6) + SUM_W'(32'sd65536);
  assign sb    = SUM_W'(ctr6) + SUM_W'(half6) + SUM_W'(32'sd65536);
  assign qa    = sa[SUM_W-1:17];
  assign qb    = sb[SUM_W-1:17];
  assign bound = $signed(Q_W'(BOUND_W'(limit) << COORD_FRAC_BITS));

  function automatic logic [16:0] clip(input logic signed [Q_W-1:0] v,
                                       input logic signed [Q_W-1:0] bnd);
    logic [16:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > bnd) begin
      r = bnd[16:0];
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    box_lo <= clip(qa, bound);
    box_hi <= clip(qb, bound);
  end

endmodule

### rtl/anchor_box_delta_decode_unit.sv
// Anchor box delta decoder: one box in per cycle, seven stage pipeline per axis.
// done comes from a valid shift register as deep as the axis pipeline, fed by each accepted start.
// Throughput: one transaction per clock; busy is high only during reset.
// Reset clears the valid pipeline and sets image_width and image_height to 1024.
// The result is held for exactly one cycle with done; the receiver cannot stall.
// Depends on abdd_pkg and abdd_axis.
module anchor_box_delta_decode_unit #(
  parameter int COORD_FRAC_BITS = abdd_pkg::COORD_FRAC_BITS_DEF,
  parameter int DELTA_FRAC_BITS = abdd_pkg::DELTA_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [16:0] anchor_left,
  input  logic signed [16:0] anchor_top,
  input  logic signed [16:0] anchor_right,
  input  logic signed [16:0] anchor_bottom,
  input  logic signed [15:0] shift_x,
  input  logic signed [15:0] shift_y,
  input  logic signed [15:0] log_scale_x,
  input  logic signed [15:0] log_scale_y,
  input  logic               in_last,
  input  logic               cfg_wr,
  input  logic [0:0]         cfg_addr,
  input  logic [12:0]        cfg_wdata,
  output logic               done,
  output logic [16:0]        box_left,
  output logic [16:0]        box_top,
  output logic [16:0]        box_right,
  output logic [16:0]        box_bottom,
  output logic               out_last
);

  localparam int DEPTH = abdd_pkg::PIPE_DEPTH;

  logic [12:0]      image_width;
  logic [12:0]      image_height;
  logic             accept;
  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] last;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd1024;
      image_height <= 13'd1024;
    end else if (cfg_wr) begin
      if (cfg_addr == abdd_pkg::REG_IMAGE_WIDTH) begin
        image_width <= cfg_wdata;
      end else begin
        image_height <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], accept};
    end
    last <= {last[DEPTH-2:0], in_last};
  end

  assign done     = vld[DEPTH-1];
  assign out_last = last[DEPTH-1];

  abdd_axis #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .DELTA_FRAC_BITS(DELTA_FRAC_BITS)
  ) u_axis_x (
    .clk       (clk),
    .lo        (anchor_left),
    .hi        (anchor_right),
    .shift     (shift_x),
    .log_scale (log_scale_x),
    .limit     (image_width),
    .box_lo    (box_left),
    .box_hi    (box_right)
  );

  abdd_axis #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .DELTA_FRAC_BITS(DELTA_FRAC_BITS)
  ) u_axis_y (
    .clk       (clk),
    .lo        (anchor_top),
    .hi        (anchor_bottom),
    .shift     (shift_y),
    .log_scale (log_scale_y),
    .limit     (image_height),
    .box_lo    (box_top),
    .box_hi    (box_bottom)
  );

  // clip bounds, only for checking
  logic [12+COORD_FRAC_BITS:0] bound_x;
  logic [12+COORD_FRAC_BITS:0] bound_y;

  assign bound_x = (13 + COORD_FRAC_BITS)'(image_width) << COORD_FRAC_BITS;
  assign bound_y = (13 + COORD_FRAC_BITS)'(image_height) << COORD_FRAC_BITS;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(abdd_pkg::PIPE_DEPTH) done)
    else $error("result strobe missing after pipeline latency");

  a_reset_flush: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !done)
    else $error("result strobe right after reset");

  a_clip_x: assert property (@(posedge clk) disable iff (rst)
    done |-> (box_left <= bound_x) && (box_right <= bound_x))
    else $error("x corner beyond clip bound");

  a_clip_y: assert property (@(posedge clk) disable iff (rst)
    done |-> (box_top <= bound_y) && (box_bottom <= bound_y))
    else $error("y corner beyond clip bound");

endmodule
